// ----- hdl/hrss_pkg.sv -----
// Package for the health ranked source selector: beat types, sizes, codes.
// No dependencies.
`default_nettype none
package hrss_pkg;
  localparam int SOURCES    = 8;
  localparam int WINDOW_MAX = 64;
  localparam int SRC_W      = $clog2(SOURCES);
  localparam int SLOT_W     = $clog2(WINDOW_MAX);
  localparam int FILL_W     = $clog2(WINDOW_MAX + 1);
  localparam int TOT_W      = FILL_W + 16;
  localparam int ADDR_W     = SRC_W + SLOT_W;
  localparam int DEPTH      = SOURCES * WINDOW_MAX;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [16:0] NO_LATENCY = 17'd100000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE   = 3'd0,
    REG_PRIORITY = 3'd1,
    REG_WEIGHT   = 3'd2,
    REG_RATE     = 3'd3,
    REG_LATENCY  = 3'd4,
    REG_WINDOW   = 3'd5,
    REG_AUTO     = 3'd6,
    REG_PREFER   = 3'd7
  } cfg_reg_t;

  localparam logic OP_SELECT = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  source_index;
    logic        success;
    logic [15:0] latency_ms;
    logic        promote;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] chosen_source;
    logic       chosen_valid;
    logic       switched;
    logic       unhealthy;
    logic [2:0] active_source;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_DROP_RD,
    ST_DROP_WAIT,
    ST_DROP_UPD,
    ST_HEALTH,
    ST_DIV,
    ST_SCAN,
    ST_DECIDE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [TOT_W-1:0] dividend;
    logic [FILL_W-1:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

// ----- hdl/hrss_ram.sv -----
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module hrss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/hrss_div.sv -----
// Restoring divider, one quotient bit a cycle, for average latency.
// Depends on hrss_pkg.
`default_nettype none
module hrss_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire hrss_pkg::div_req_t           req,
  output logic                              busy,
  output logic [hrss_pkg::TOT_W-1:0]        quot
);
  localparam int CW = $clog2(hrss_pkg::TOT_W + 1);
  logic [hrss_pkg::TOT_W-1:0]  q_r, q_nxt;
  logic [hrss_pkg::FILL_W:0]   rem_r, rem_nxt;
  logic [hrss_pkg::FILL_W-1:0] d_r, d_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [hrss_pkg::FILL_W:0]   sh;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    sh = '0;
    if (req.start) begin
      q_nxt = req.dividend;
      rem_nxt = '0;
      d_nxt = req.divisor;
      cnt_nxt = CW'(hrss_pkg::TOT_W);
    end else if (cnt_r != '0) begin
      sh = {rem_r[hrss_pkg::FILL_W-1:0], q_r[hrss_pkg::TOT_W-1]};
      q_nxt = {q_r[hrss_pkg::TOT_W-2:0], 1'b0};
      if (sh >= {1'b0, d_r}) begin
        sh = sh - {1'b0, d_r};
        q_nxt[0] = 1'b1;
      end
      rem_nxt = sh;
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    d_r <= d_nxt;
  end

  assign busy = (cnt_r != '0) || req.start;
  assign quot = q_r;
endmodule
`default_nettype wire

// ----- hdl/health_ranked_source_selector_unit.sv -----
// Top level of the health ranked source selector: control sequencer,
// per-source counters and window memory. Depends on hrss_pkg, hrss_ram, hrss_div.
`default_nettype none
// One beat in, one beat out. A record beat writes the window memory (a full
// window first drops its oldest entry) and then drops surplus old entries, one
// memory read per dropped entry, then computes the source's health with a serial
// divide. A select beat computes the health and average latency of every source
// through the shared serial divider; a pinned preferred source still takes that
// path. The window memory needs no clearing after reset. A finished result sits
// in an output register; the next beat is taken once it has been handed on.
module health_ranked_source_selector_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire hrss_pkg::in_beat_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output hrss_pkg::out_beat_t                     out_data,
  input  wire logic                               cfg_we,
  input  wire logic [hrss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hrss_pkg::CFG_DATA_W-1:0]    cfg_data
);
  localparam int SW = hrss_pkg::SRC_W;
  localparam int FW = hrss_pkg::FILL_W;
  localparam int TW = hrss_pkg::TOT_W;
  localparam int PW = hrss_pkg::SLOT_W;

  logic [7:0]  enable_r;
  logic [31:0] prio_r;
  logic [63:0] weight_r;
  logic [6:0]  rate_r;
  logic [15:0] latlim_r;
  logic [6:0]  wsize_r;
  logic        auto_r;
  logic [2:0]  pref_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 8'hFF;
      prio_r <= '0;
      weight_r <= '0;
      rate_r <= 7'd80;
      latlim_r <= 16'd1500;
      wsize_r <= 7'd20;
      auto_r <= 1'b1;
      pref_r <= '0;
    end else if (cfg_we) begin
      case (hrss_pkg::cfg_reg_t'(cfg_index))
        hrss_pkg::REG_ENABLE:   enable_r <= cfg_data[7:0];
        hrss_pkg::REG_PRIORITY: prio_r <= cfg_data[31:0];
        hrss_pkg::REG_WEIGHT:   weight_r <= cfg_data;
        hrss_pkg::REG_RATE:     rate_r <= cfg_data[6:0];
        hrss_pkg::REG_LATENCY:  latlim_r <= cfg_data[15:0];
        hrss_pkg::REG_WINDOW:   wsize_r <= cfg_data[6:0];
        hrss_pkg::REG_AUTO:     auto_r <= cfg_data[0];
        hrss_pkg::REG_PREFER:   pref_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic [FW-1:0] fill_r [hrss_pkg::SOURCES];
  logic [PW-1:0] old_r  [hrss_pkg::SOURCES];
  logic [FW-1:0] okc_r  [hrss_pkg::SOURCES];
  logic [TW-1:0] tot_r  [hrss_pkg::SOURCES];
  logic [SW-1:0] cur_r, cur_nxt;

  hrss_pkg::state_t state_r, state_nxt;
  hrss_pkg::in_beat_t beat_r;
  hrss_pkg::out_beat_t obeat_r, obeat_nxt;
  logic [SW-1:0] src_r, src_nxt;
  logic [SW-1:0] best_r, best_nxt;
  logic          found_r, found_nxt;
  logic          bunh_r, bunh_nxt;
  logic [16:0]   blat_r, blat_nxt;
  logic          unh_r, unh_nxt;
  logic [SW:0]   sel_mode_r, sel_mode_nxt;

  // window memory
  logic mem_we;
  logic [hrss_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [16:0] mem_wdata, mem_rdata;
  hrss_ram #(.WIDTH(17), .DEPTH(hrss_pkg::DEPTH)) u_win (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  hrss_pkg::div_req_t dreq;
  logic          dbusy;
  logic [TW-1:0] dquot;
  hrss_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .quot(dquot));

  logic [SW-1:0] s_i;
  logic [FW-1:0] f_s, ok_s;
  logic [TW-1:0] t_s;
  logic [FW-1:0] limit;
  logic [6:0]    minw;
  logic          rate_bad, lat_bad, unh_c;
  logic [TW-1:0] avg;
  logic [16:0]   lat_key;
  logic [3:0]    p_s, p_b;
  logic [7:0]    w_s, w_b;
  logic          better;
  logic [13:0]   rn_s, rn_b;
  logic [13:0]   xa, xb;
  logic [FW-1:0] ra_n, ra_d, rb_n, rb_d;

  assign s_i  = src_r;
  assign f_s  = fill_r[s_i];
  assign ok_s = okc_r[s_i];
  assign t_s  = tot_r[s_i];
  assign minw = (wsize_r[6:2] < 5'd3) ? 7'd3 : {2'b0, wsize_r[6:2]};
  assign rate_bad = ({7'b0, ok_s} * 14'd100) < ({7'b0, rate_r} * {7'b0, f_s});
  assign avg = (ok_s == '0) ? '0 : dquot;
  assign lat_bad = avg > TW'(latlim_r);
  assign unh_c = ({1'b0, f_s} >= {1'b0, minw}) && (rate_bad || lat_bad);
  assign lat_key = (avg == '0) ? hrss_pkg::NO_LATENCY : avg[16:0];
  assign p_s = prio_r[4*s_i +: 4];
  assign p_b = prio_r[4*best_r +: 4];
  assign w_s = weight_r[8*s_i +: 8];
  assign w_b = weight_r[8*best_r +: 8];
  assign ra_n = (f_s == '0) ? FW'(1) : ok_s;
  assign ra_d = (f_s == '0) ? FW'(1) : f_s;
  assign rb_n = (fill_r[best_r] == '0) ? FW'(1) : okc_r[best_r];
  assign rb_d = (fill_r[best_r] == '0) ? FW'(1) : fill_r[best_r];
  assign xa = ra_n * rb_d;
  assign xb = rb_n * ra_d;
  assign rn_s = '0;
  assign rn_b = '0;

  always_comb begin
    if (unh_c != bunh_r) better = !unh_c;
    else if (p_s != p_b) better = p_s < p_b;
    else if (w_s != w_b) better = w_s > w_b;
    else if (lat_key != blat_r) better = lat_key < blat_r;
    else better = (xa + rn_s) > (xb + rn_b);
  end

  always_comb begin
    limit = (wsize_r < 7'd5) ? FW'(5) :
            (wsize_r > 7'(hrss_pkg::WINDOW_MAX)) ? FW'(hrss_pkg::WINDOW_MAX) : FW'(wsize_r);
  end

  logic [PW-1:0] wslot;
  assign wslot = old_r[s_i] + f_s[PW-1:0];

  logic ld_push, ld_fullpop, ld_drop;
  always_comb begin
    state_nxt = state_r;
    obeat_nxt = obeat_r;
    src_nxt = src_r;
    best_nxt = best_r;
    found_nxt = found_r;
    bunh_nxt = bunh_r;
    blat_nxt = blat_r;
    unh_nxt = unh_r;
    cur_nxt = cur_r;
    sel_mode_nxt = sel_mode_r;
    mem_we = 1'b0;
    mem_waddr = {s_i, wslot};
    mem_wdata = {beat_r.success, beat_r.latency_ms};
    mem_raddr = {s_i, old_r[s_i]};
    dreq = '{start: 1'b0, dividend: t_s, divisor: ok_s};
    ld_push = 1'b0;
    ld_fullpop = 1'b0;
    ld_drop = 1'b0;
    in_ready = (state_r == hrss_pkg::ST_IDLE);
    case (state_r)
      hrss_pkg::ST_IDLE: begin
        if (in_valid) begin
          src_nxt = in_data.source_index;
          found_nxt = 1'b0;
          state_nxt = (in_data.opcode == hrss_pkg::OP_RECORD) ? hrss_pkg::ST_PUSH
                                                             : hrss_pkg::ST_HEALTH;
          if (in_data.opcode == hrss_pkg::OP_SELECT) src_nxt = '0;
        end
      end
      hrss_pkg::ST_PUSH: begin
        // full window: the new beat overwrites the oldest slot
        if (f_s == FW'(hrss_pkg::WINDOW_MAX)) begin
          state_nxt = hrss_pkg::ST_DROP_WAIT;
          ld_fullpop = 1'b1;
        end else begin
          mem_we = 1'b1;
          ld_push = 1'b1;
          state_nxt = hrss_pkg::ST_DROP_RD;
        end
      end
      hrss_pkg::ST_DROP_RD: begin
        state_nxt = (f_s > limit) ? hrss_pkg::ST_DROP_WAIT : hrss_pkg::ST_HEALTH;
      end
      hrss_pkg::ST_DROP_WAIT: begin
        state_nxt = hrss_pkg::ST_DROP_UPD;
      end
      hrss_pkg::ST_DROP_UPD: begin
        ld_drop = 1'b1;
        state_nxt = sel_mode_r[SW] ? hrss_pkg::ST_PUSH : hrss_pkg::ST_DROP_RD;
        sel_mode_nxt[SW] = 1'b0;
      end
      hrss_pkg::ST_HEALTH: begin
        dreq.start = 1'b1;
        state_nxt = hrss_pkg::ST_DIV;
      end
      hrss_pkg::ST_DIV: begin
        if (!dbusy) begin
          if (beat_r.opcode == hrss_pkg::OP_RECORD) begin
            if (beat_r.promote && beat_r.success && s_i != cur_r) cur_nxt = s_i;
            obeat_nxt = '{chosen_source: s_i, chosen_valid: 1'b1,
                          switched: beat_r.promote && beat_r.success && s_i != cur_r,
                          unhealthy: unh_c, active_source: cur_nxt};
            state_nxt = hrss_pkg::ST_OUT;
          end else begin
            state_nxt = hrss_pkg::ST_SCAN;
          end
        end
      end
      hrss_pkg::ST_SCAN: begin
        if (s_i == cur_r) unh_nxt = unh_c;
        if (enable_r[s_i] && (!found_r || better)) begin
          found_nxt = 1'b1;
          best_nxt = s_i;
          bunh_nxt = unh_c;
          blat_nxt = lat_key;
        end
        if (s_i == pref_r) sel_mode_nxt[0] = unh_c;
        if (s_i == SW'(hrss_pkg::SOURCES - 1)) begin
          state_nxt = hrss_pkg::ST_DECIDE;
        end else begin
          src_nxt = s_i + SW'(1);
          state_nxt = hrss_pkg::ST_HEALTH;
        end
      end
      hrss_pkg::ST_DECIDE: begin
        if (!auto_r && enable_r[pref_r]) begin
          obeat_nxt = '{chosen_source: pref_r, chosen_valid: 1'b1,
                        switched: pref_r != cur_r, unhealthy: sel_mode_r[0],
                        active_source: pref_r};
          cur_nxt = pref_r;
        end else if (enable_r[cur_r] && !unh_r) begin
          obeat_nxt = '{chosen_source: cur_r, chosen_valid: 1'b1, switched: 1'b0,
                        unhealthy: 1'b0, active_source: cur_r};
        end else if (found_r) begin
          obeat_nxt = '{chosen_source: best_r, chosen_valid: 1'b1,
                        switched: best_r != cur_r, unhealthy: bunh_r,
                        active_source: best_r};
          cur_nxt = best_r;
        end else begin
          obeat_nxt = '{chosen_source: '0, chosen_valid: 1'b0, switched: 1'b0,
                        unhealthy: 1'b0, active_source: cur_r};
        end
        state_nxt = hrss_pkg::ST_OUT;
      end
      hrss_pkg::ST_OUT: begin
        if (out_ready) state_nxt = hrss_pkg::ST_IDLE;
      end
      default: state_nxt = hrss_pkg::ST_IDLE;
    endcase
    if (ld_fullpop) sel_mode_nxt[SW] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hrss_pkg::ST_IDLE;
      cur_r <= '0;
      sel_mode_r <= '0;
      for (int i = 0; i < hrss_pkg::SOURCES; i++) begin
        fill_r[i] <= '0;
        old_r[i] <= '0;
        okc_r[i] <= '0;
        tot_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cur_r <= cur_nxt;
      sel_mode_r <= sel_mode_nxt;
      if (ld_push) begin
        fill_r[s_i] <= f_s + FW'(1);
        if (beat_r.success) begin
          okc_r[s_i] <= ok_s + FW'(1);
          tot_r[s_i] <= t_s + TW'(beat_r.latency_ms);
        end
      end else if (ld_drop) begin
        fill_r[s_i] <= f_s - FW'(1);
        old_r[s_i] <= old_r[s_i] + PW'(1);
        if (mem_rdata[16]) begin
          okc_r[s_i] <= ok_s - FW'(1);
          tot_r[s_i] <= t_s - TW'(mem_rdata[15:0]);
        end
      end
    end
    if (state_r == hrss_pkg::ST_IDLE && in_valid) beat_r <= in_data;
    src_r <= src_nxt;
    best_r <= best_nxt;
    found_r <= found_nxt;
    bunh_r <= bunh_nxt;
    blat_r <= blat_nxt;
    unh_r <= unh_nxt;
    obeat_r <= obeat_nxt;
  end

  assign out_valid = (state_r == hrss_pkg::ST_OUT);
  assign out_data = obeat_r;
endmodule
`default_nettype wire

// ----- hdl/hrss_checker.sv -----
// Port-level checker for the selector, bound to the top level.
// Depends on hrss_pkg.
`default_nettype none
module hrss_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire hrss_pkg::in_beat_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire hrss_pkg::out_beat_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.chosen_valid && out_data.switched |->
      out_data.active_source == out_data.chosen_source)
    else $error("switch without active update");
  a_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.chosen_valid |-> !out_data.switched && !out_data.unhealthy)
    else $error("invalid choice with flags");
endmodule

bind health_ranked_source_selector_unit hrss_checker u_hrss_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

// ----- bench/hrss_checker.sv -----
// Checker for the health ranked source selector: watches both channels,
// predicts each result beat from a local copy of state and registers.
// Depends on hrss_pkg.
`timescale 1ns / 1ps
module hrss_scoreboard (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  hrss_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  hrss_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output int                  fail_count,
  output int                  pending
);
  localparam int QD = 16;

  logic        win_ok  [hrss_pkg::SOURCES][hrss_pkg::WINDOW_MAX];
  logic [15:0] win_lat [hrss_pkg::SOURCES][hrss_pkg::WINDOW_MAX];
  int unsigned fill [hrss_pkg::SOURCES];
  int unsigned head [hrss_pkg::SOURCES];
  int unsigned oks  [hrss_pkg::SOURCES];
  int unsigned tot  [hrss_pkg::SOURCES];
  int unsigned active;

  logic [7:0]  en_mask;
  logic [31:0] prio_w;
  logic [63:0] wgt_w;
  int unsigned rate_th, lat_lim, win_sz, auto_sw, pref;

  hrss_pkg::out_beat_t exp_mem [QD];
  int unsigned wr_ptr, rd_ptr;

  assign pending = int'(wr_ptr - rd_ptr);

  function automatic bit is_bad(int unsigned s);
    int unsigned minw;
    minw = win_sz / 4;
    if (minw < 3) minw = 3;
    if (fill[s] < minw) return 0;
    if (oks[s] * 100 < rate_th * fill[s]) return 1;
    return (oks[s] ? tot[s] / oks[s] : 0) > lat_lim;
  endfunction

  function automatic bit outranks(int unsigned a, int unsigned b);
    bit ua, ub;
    int unsigned pa, pb, wa, wb, la, lb;
    longint unsigned an, ad, bn, bd;
    ua = is_bad(a);
    ub = is_bad(b);
    if (ua != ub) return !ua;
    pa = (prio_w >> (4 * a)) & 15;
    pb = (prio_w >> (4 * b)) & 15;
    if (pa != pb) return pa < pb;
    wa = (wgt_w >> (8 * a)) & 255;
    wb = (wgt_w >> (8 * b)) & 255;
    if (wa != wb) return wa > wb;
    la = oks[a] ? tot[a] / oks[a] : 0;
    lb = oks[b] ? tot[b] / oks[b] : 0;
    if (la == 0) la = 100000;
    if (lb == 0) lb = 100000;
    if (la != lb) return la < lb;
    an = fill[a] ? oks[a] : 1;
    ad = fill[a] ? fill[a] : 1;
    bn = fill[b] ? oks[b] : 1;
    bd = fill[b] ? fill[b] : 1;
    return an * bd > bn * ad;
  endfunction

  task automatic drop_entry(int unsigned s);
    if (win_ok[s][head[s]]) begin
      oks[s]--;
      tot[s] -= win_lat[s][head[s]];
    end
    head[s] = (head[s] + 1) % hrss_pkg::WINDOW_MAX;
    fill[s]--;
  endtask

  task automatic predict_beat(hrss_pkg::in_beat_t b);
    hrss_pkg::out_beat_t r;
    int unsigned idx, lim, ch;
    bit found;
    r = '0;
    idx = b.source_index;
    if (b.opcode == hrss_pkg::OP_RECORD) begin
      lim = win_sz < 5 ? 5 : win_sz;
      if (lim > hrss_pkg::WINDOW_MAX) lim = hrss_pkg::WINDOW_MAX;
      if (fill[idx] >= hrss_pkg::WINDOW_MAX) drop_entry(idx);
      win_ok[idx][(head[idx] + fill[idx]) % hrss_pkg::WINDOW_MAX] = b.success;
      win_lat[idx][(head[idx] + fill[idx]) % hrss_pkg::WINDOW_MAX] = b.latency_ms;
      fill[idx]++;
      if (b.success) begin
        oks[idx]++;
        tot[idx] += b.latency_ms;
      end
      while (fill[idx] > lim) drop_entry(idx);
      if (b.promote && b.success && idx != active) begin
        active = idx;
        r.switched = 1;
      end
      r.chosen_source = 3'(idx);
      r.chosen_valid = 1;
      r.unhealthy = is_bad(idx);
    end else begin
      found = 0;
      ch = 0;
      if (!auto_sw && en_mask[pref]) begin
        ch = pref;
        found = 1;
      end else if (en_mask[active] && !is_bad(active)) begin
        ch = active;
        found = 1;
      end else begin
        for (int unsigned s = 0; s < hrss_pkg::SOURCES; s++) begin
          if (en_mask[s] && (!found || outranks(s, ch))) begin
            ch = s;
            found = 1;
          end
        end
      end
      if (found) begin
        r.chosen_valid = 1;
        if (ch != active) begin
          active = ch;
          r.switched = 1;
        end
        r.unhealthy = is_bad(ch);
        r.chosen_source = 3'(ch);
      end
    end
    r.active_source = 3'(active);
    exp_mem[wr_ptr % QD] = r;
    wr_ptr++;
  endtask

  always @(posedge clk) begin
    hrss_pkg::out_beat_t e;
    if (!rst_n) begin
      for (int s = 0; s < hrss_pkg::SOURCES; s++) begin
        fill[s] = 0;
        head[s] = 0;
        oks[s] = 0;
        tot[s] = 0;
      end
      active = 0;
      en_mask = 8'hFF;
      prio_w = 0;
      wgt_w = 0;
      rate_th = 80;
      lat_lim = 1500;
      win_sz = 20;
      auto_sw = 1;
      pref = 0;
      wr_ptr = 0;
      rd_ptr = 0;
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (hrss_pkg::cfg_reg_t'(cfg_index))
          hrss_pkg::REG_ENABLE:   en_mask = cfg_data[7:0];
          hrss_pkg::REG_PRIORITY: prio_w = cfg_data[31:0];
          hrss_pkg::REG_WEIGHT:   wgt_w = cfg_data;
          hrss_pkg::REG_RATE:     rate_th = cfg_data[6:0];
          hrss_pkg::REG_LATENCY:  lat_lim = cfg_data[15:0];
          hrss_pkg::REG_WINDOW:   win_sz = cfg_data[6:0];
          hrss_pkg::REG_AUTO:     auto_sw = cfg_data[0];
          hrss_pkg::REG_PREFER:   pref = cfg_data[2:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (wr_ptr == rd_ptr) begin
          $error("result beat with no expectation: %p", out_data);
          fail_count++;
        end else begin
          e = exp_mem[rd_ptr % QD];
          rd_ptr++;
          if (out_data.chosen_source !== e.chosen_source) begin
            $error("chosen_source exp %0d got %0d", e.chosen_source, out_data.chosen_source);
            fail_count++;
          end
          if (out_data.chosen_valid !== e.chosen_valid) begin
            $error("chosen_valid exp %0d got %0d", e.chosen_valid, out_data.chosen_valid);
            fail_count++;
          end
          if (out_data.switched !== e.switched) begin
            $error("switched exp %0d got %0d", e.switched, out_data.switched);
            fail_count++;
          end
          if (out_data.unhealthy !== e.unhealthy) begin
            $error("unhealthy exp %0d got %0d", e.unhealthy, out_data.unhealthy);
            fail_count++;
          end
          if (out_data.active_source !== e.active_source) begin
            $error("active_source exp %0d got %0d", e.active_source, out_data.active_source);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_beat(in_data);
    end
  end
endmodule

// ----- bench/testbench.sv -----
// Top of the selector bench: clock, reset, register phases, beat stimulus
// and verdict. Depends on hrss_pkg, hrss_scoreboard and the selector unit.
`timescale 1ns / 1ps
module testbench;
  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_valid = 0;
  logic                in_ready;
  hrss_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 0;
  hrss_pkg::out_beat_t out_data;
  logic                cfg_we = 0;
  logic [2:0]          cfg_index = 0;
  logic [63:0]         cfg_data = 0;
  int                  fail_count, pending;
  bit                  sink_on = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  health_ranked_source_selector_unit DUT (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  hrss_scoreboard chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending
  );

  // receiver: random stall before each beat
  initial begin
    int gap;
    wait (sink_on);
    forever begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(posedge clk);
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      out_ready <= 0;
    end
  end

  task automatic write_reg(hrss_pkg::cfg_reg_t r, logic [63:0] v);
    cfg_we <= 1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic send_beat(hrss_pkg::in_beat_t b, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic hrss_pkg::in_beat_t make_beat(int src_max, int bias);
    hrss_pkg::in_beat_t b;
    b.opcode = ($urandom_range(0, 99) < bias) ? hrss_pkg::OP_RECORD : hrss_pkg::OP_SELECT;
    b.source_index = 3'($urandom_range(0, src_max));
    b.success = $urandom_range(0, 3) != 0;
    case ($urandom_range(0, 5))
      0: b.latency_ms = 16'hFFFF;
      1: b.latency_ms = 16'($urandom);
      2: b.latency_ms = 16'd0;
      default: b.latency_ms = 16'($urandom_range(0, 3000));
    endcase
    b.promote = $urandom_range(0, 3) == 0;
    return b;
  endfunction

  task automatic random_regs;
    write_reg(hrss_pkg::REG_ENABLE, ($urandom_range(0, 4) == 0) ? 64'h0 : 64'($urandom));
    write_reg(hrss_pkg::REG_PRIORITY, ($urandom_range(0, 1)) ? 64'h0 : 64'($urandom));
    write_reg(hrss_pkg::REG_WEIGHT, ($urandom_range(0, 1)) ? 64'h0 : {$urandom, $urandom});
    write_reg(hrss_pkg::REG_RATE, 64'($urandom_range(0, 100)));
    write_reg(hrss_pkg::REG_LATENCY,
              ($urandom_range(0, 2) == 0) ? 64'($urandom) : 64'($urandom_range(0, 3000)));
    write_reg(hrss_pkg::REG_WINDOW, 64'($urandom_range(5, 64)));
    write_reg(hrss_pkg::REG_AUTO, 64'($urandom_range(0, 1)));
    write_reg(hrss_pkg::REG_PREFER, 64'($urandom_range(0, 7)));
  endtask

  initial begin
    hrss_pkg::in_beat_t b;
    bit burst;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    sink_on = 1;
    @(posedge clk);

    // directed: a record on every source, extremes, no-enable select, pinned source
    for (int i = 0; i < 8; i++) begin
      b = '{hrss_pkg::OP_RECORD, 3'(i), 1'b1, (i == 0) ? 16'hFFFF : 16'd0, 1'b1};
      send_beat(b, 0);
    end
    for (int i = 0; i < 5; i++) begin
      b = '{hrss_pkg::OP_RECORD, 3'd2, 1'b0, 16'd100, 1'b0};
      send_beat(b, 0);
    end
    b = '{hrss_pkg::OP_SELECT, 3'd7, 1'b1, 16'hFFFF, 1'b1};
    send_beat(b, 0);
    drain();
    write_reg(hrss_pkg::REG_ENABLE, 64'h00);
    write_reg(hrss_pkg::REG_AUTO, 64'd0);
    write_reg(hrss_pkg::REG_PREFER, 64'd7);
    write_reg(hrss_pkg::REG_RATE, 64'd100);
    write_reg(hrss_pkg::REG_LATENCY, 64'd0);
    send_beat('{hrss_pkg::OP_SELECT, 3'd0, 1'b0, 16'd0, 1'b0}, 0);
    send_beat('{hrss_pkg::OP_RECORD, 3'd5, 1'b1, 16'd10, 1'b1}, 0);
    drain();
    write_reg(hrss_pkg::REG_ENABLE, 64'h80);
    write_reg(hrss_pkg::REG_WINDOW, 64'd64);
    write_reg(hrss_pkg::REG_PRIORITY, 64'hFFFF_FFFF);
    write_reg(hrss_pkg::REG_WEIGHT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat('{hrss_pkg::OP_SELECT, 3'd0, 1'b0, 16'd0, 1'b0}, 0);
    for (int i = 0; i < 6; i++) begin
      send_beat('{hrss_pkg::OP_RECORD, 3'd1, 1'b1, 16'hFFFF, 1'b0}, 0);
    end
    drain();
    // lowered limit drops several entries on next push
    write_reg(hrss_pkg::REG_WINDOW, 64'd5);
    write_reg(hrss_pkg::REG_AUTO, 64'd1);
    write_reg(hrss_pkg::REG_ENABLE, 64'hFF);
    send_beat('{hrss_pkg::OP_RECORD, 3'd1, 1'b0, 16'd5, 1'b0}, 0);
    send_beat('{hrss_pkg::OP_SELECT, 3'd0, 1'b0, 16'd0, 1'b0}, 0);
    drain();

    // random phases
    for (int ph = 0; ph < 26; ph++) begin
      random_regs();
      if (ph == 3) begin
        write_reg(hrss_pkg::REG_WINDOW, 64'd127);
        write_reg(hrss_pkg::REG_RATE, 64'd0);
      end
      burst = (ph % 4 == 1);
      for (int i = 0; i < 50; i++) begin
        b = make_beat((ph % 3 == 0) ? 1 : 7, 75);
        send_beat(b, burst);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
